FILE: rtl/core/pph_pkg.sv
// Package for the polyline pick hit-test core.
// Holds shared widths, hit-kind codes, config indices and the controller-datapath command and status structs.
// No dependencies.
package pph_pkg;

  localparam int COORD_W      = 13;
  localparam int RADIUS_W     = 8;
  localparam int COUNT_W      = 7;
  localparam int CFG_W        = 8;
  localparam int INDEX_W      = 6;
  localparam int KIND_W       = 2;
  localparam int MAX_VERT_DEF = 64;

  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VERTEX  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEGMENT = 2'd2;

  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  // Datapath step commands issued by the controller.
  localparam logic [3:0] CMD_IDLE  = 4'd0;
  localparam logic [3:0] CMD_VTX   = 4'd1;  // vertex distance from read data
  localparam logic [3:0] CMD_SEGA  = 4'd2;  // latch end vertex v
  localparam logic [3:0] CMD_SEGB  = 4'd3;  // latch start vertex w, form deltas
  localparam logic [3:0] CMD_SEGC  = 4'd4;  // l2 and d products
  localparam logic [3:0] CMD_SEGD  = 4'd5;  // sums, start divide
  localparam logic [3:0] CMD_DIV   = 4'd6;  // clamp check, then one quotient bit
  localparam logic [3:0] CMD_SEGE  = 4'd7;  // projection error
  localparam logic [3:0] CMD_SEGF  = 4'd8;  // squares
  localparam logic [3:0] CMD_SEGG  = 4'd9;  // sum and compare

  typedef struct packed {
    logic [3:0] op;
  } pph_cmd_t;

  typedef struct packed {
    logic hit;
    logic div_done;
  } pph_stat_t;

endpackage

FILE: rtl/core/polyline_pick_hit_test_core.sv
// Top level of the polyline pick hit-test core: registers, controller and datapath.
// Depends on pph_pkg, pph_ctrl, pph_datapath.
//
// Channel | Handshake            | Payload
// in_     | start / busy         | in_opcode, in_vertex_index, in_coord_x, in_coord_y
// out_    | out_valid strobe     | out_hit_kind, out_hit_index
// cfg_    | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A load is accepted while busy stays low. A query holds busy through the vertex
// scan, then the segment scan, where each segment passes through the 16-step restoring
// divider unless t clamps, plus a closing state before idle.
// The result strobe rises in the same cycle that busy falls.
// Synchronous active-low reset sets radius 5 and count 0; vertex memory is not cleared.
// The result strobe lasts one cycle and the receiver cannot stall it.
module polyline_pick_hit_test_core #(
  parameter int MAX_VERTICES = pph_pkg::MAX_VERT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_opcode,
  input  logic [pph_pkg::INDEX_W-1:0]        in_vertex_index,
  input  logic signed [pph_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pph_pkg::COORD_W-1:0] in_coord_y,
  output logic                               out_valid,
  output logic [pph_pkg::KIND_W-1:0]         out_hit_kind,
  output logic [pph_pkg::INDEX_W-1:0]        out_hit_index,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [pph_pkg::CFG_W-1:0]          cfg_data
);
  import pph_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  logic [RADIUS_W-1:0] radius_r;
  logic [COUNT_W-1:0]  count_r;
  logic                acc, we, query;
  pph_cmd_t            cmd;
  pph_stat_t           stat;
  logic [AW-1:0]       raddr;

  assign acc       = start && !busy;
  assign we        = acc && !in_opcode && (32'(in_vertex_index) < MAX_VERTICES);
  assign query     = acc && in_opcode;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_W'(5);
      count_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RADIUS: radius_r <= cfg_data[RADIUS_W-1:0];
        CFG_COUNT:  count_r  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  pph_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .query(query), .count(count_r), .stat(stat),
    .busy(busy), .raddr(raddr), .cmd(cmd), .done(out_valid),
    .kind(out_hit_kind), .index(out_hit_index)
  );

  pph_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk(clk), .we(we), .waddr(in_vertex_index[AW-1:0]), .wx(in_coord_x),
    .wy(in_coord_y), .raddr(raddr), .qload(query), .radius(radius_r),
    .cmd(cmd), .stat(stat)
  );

endmodule

FILE: rtl/core/pph_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pph_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/pph_datapath.sv
// Datapath of the polyline pick core: vertex store, distance arithmetic and divider.
// Depends on pph_pkg and pph_ram.
module pph_datapath #(
  parameter int MAX_VERTICES = pph_pkg::MAX_VERT_DEF,
  localparam int AW = $clog2(MAX_VERTICES)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic signed [pph_pkg::COORD_W-1:0] wx,
  input  logic signed [pph_pkg::COORD_W-1:0] wy,
  input  logic [AW-1:0]                 raddr,
  input  logic                          qload,
  input  logic [pph_pkg::RADIUS_W-1:0]  radius,
  input  pph_pkg::pph_cmd_t             cmd,
  output pph_pkg::pph_stat_t            stat
);
  import pph_pkg::*;

  logic signed [COORD_W-1:0] rx, ry;
  logic signed [COORD_W-1:0] px_r, py_r, vx_r, vy_r;
  logic signed [COORD_W:0]   ex_r, ey_r, ax_r, ay_r;
  logic signed [28:0]        m0_r, m1_r, m2_r, m3_r;
  logic [28:0]               l2_r;
  logic signed [29:0]        d_r;
  logic [16:0]               t_r;
  logic [45:0]               rem_r;
  logic [4:0]                dcnt_r;
  logic signed [32:0]        dx_r, dy_r;
  logic [65:0]               sx_r, sy_r;
  logic [17:0]               r2_r;
  logic                      zero_r;
  logic                      hit_r, div_done_r;

  pph_ram #(.WIDTH(COORD_W), .DEPTH(MAX_VERTICES)) u_ram_x (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wx), .raddr(raddr), .rdata(rx)
  );
  pph_ram #(.WIDTH(COORD_W), .DEPTH(MAX_VERTICES)) u_ram_y (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wy), .raddr(raddr), .rdata(ry)
  );

  logic signed [COORD_W:0] vdx, vdy;
  logic [27:0]             vsq;
  logic [45:0]             trial;
  logic [33:0]             tex, tey;

  always_comb begin
    vdx   = $signed({rx[COORD_W-1], rx}) - $signed({px_r[COORD_W-1], px_r});
    vdy   = $signed({ry[COORD_W-1], ry}) - $signed({py_r[COORD_W-1], py_r});
    vsq   = 28'(vdx * vdx) + 28'(vdy * vdy);
    trial = {rem_r[44:0], 1'b0} - 46'(l2_r);
    tex   = 34'($signed({1'b0, t_r}) * ex_r);
    tey   = 34'($signed({1'b0, t_r}) * ey_r);
  end

  // Step registers driven by the controller command.
  always_ff @(posedge clk) begin
    if (qload) begin
      px_r <= wx;
      py_r <= wy;
      r2_r <= 18'(radius * radius);
    end
    hit_r      <= 1'b0;
    div_done_r <= 1'b0;
    unique case (cmd.op)
      CMD_VTX:  hit_r <= (vsq <= 28'(r2_r));
      CMD_SEGA: begin
        vx_r <= rx;
        vy_r <= ry;
        ax_r <= vdx;
        ay_r <= vdy;
      end
      CMD_SEGB: begin
        ex_r <= $signed({rx[COORD_W-1], rx}) - $signed({vx_r[COORD_W-1], vx_r});
        ey_r <= $signed({ry[COORD_W-1], ry}) - $signed({vy_r[COORD_W-1], vy_r});
        ax_r <= -ax_r;
        ay_r <= -ay_r;
      end
      CMD_SEGC: begin
        m0_r <= 29'(ex_r * ex_r);
        m1_r <= 29'(ey_r * ey_r);
        m2_r <= 29'(ax_r * ex_r);
        m3_r <= 29'(ay_r * ey_r);
      end
      CMD_SEGD: begin
        l2_r   <= 29'(m0_r + m1_r);
        d_r    <= 30'(m2_r) + 30'(m3_r);
        dcnt_r <= 5'd0;
        t_r    <= 17'd0;
      end
      CMD_DIV: begin
        // Restoring division, one quotient bit per cycle, after clamping.
        if (dcnt_r == 5'd0) begin
          zero_r <= (l2_r == 29'd0);
          if (d_r <= 0) begin
            t_r <= 17'd0;
            div_done_r <= 1'b1;
          end else if (46'(d_r) >= 46'(l2_r)) begin
            t_r <= 17'h10000;
            div_done_r <= 1'b1;
          end else begin
            rem_r  <= 46'(d_r);
            dcnt_r <= 5'd1;
          end
        end else begin
          if (!trial[45]) begin
            rem_r <= trial;
            t_r   <= {t_r[15:0], 1'b1};
          end else begin
            rem_r <= {rem_r[44:0], 1'b0};
            t_r   <= {t_r[15:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 5'd1;
          if (dcnt_r == 5'd16) div_done_r <= 1'b1;
        end
      end
      CMD_SEGE: begin
        if (zero_r) begin
          dx_r <= 33'($signed({ax_r, 16'd0}));
          dy_r <= 33'($signed({ay_r, 16'd0}));
        end else begin
          dx_r <= 33'($signed({ax_r, 16'd0})) - 33'(tex);
          dy_r <= 33'($signed({ay_r, 16'd0})) - 33'(tey);
        end
      end
      CMD_SEGF: begin
        sx_r <= 66'(dx_r * dx_r);
        sy_r <= 66'(dy_r * dy_r);
      end
      CMD_SEGG: hit_r <= (67'(sx_r) + 67'(sy_r)) <= {17'd0, r2_r, 32'd0};
      default: ;
    endcase
  end

  assign stat.hit      = hit_r;
  assign stat.div_done = div_done_r;

endmodule

FILE: rtl/core/pph_ctrl.sv
// Controller state machine: sequences vertex scan, then segment scan if no vertex hits, and reports.
// Depends on pph_pkg.
module pph_ctrl #(
  parameter int MAX_VERTICES = pph_pkg::MAX_VERT_DEF,
  localparam int AW = $clog2(MAX_VERTICES)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          query,
  input  logic [pph_pkg::COUNT_W-1:0]   count,
  input  pph_pkg::pph_stat_t            stat,
  output logic                          busy,
  output logic [AW-1:0]                 raddr,
  output pph_pkg::pph_cmd_t             cmd,
  output logic                          done,
  output logic [pph_pkg::KIND_W-1:0]    kind,
  output logic [pph_pkg::INDEX_W-1:0]   index
);
  import pph_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_VRD = 4'd1, S_VCHK = 4'd2, S_VRES = 4'd3,
                         S_SRD = 4'd4, S_SA = 4'd5, S_SB = 4'd6, S_SC = 4'd7,
                         S_SD = 4'd8, S_DIV = 4'd9, S_SE = 4'd10, S_SF = 4'd11,
                         S_SRES = 4'd13;

  logic [3:0]  state_r, state_nxt;
  logic [AW:0] i_r, i_nxt, n_r, n_nxt;
  logic        done_r;
  logic [KIND_W-1:0] kind_r;
  logic [INDEX_W-1:0] index_r;
  logic [AW:0] ncap;

  assign ncap = (32'(count) > MAX_VERTICES) ? (AW+1)'(MAX_VERTICES) : (AW+1)'(count);

  // Next-state logic and datapath commands.
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    cmd.op    = CMD_IDLE;
    raddr     = i_r[AW-1:0];
    unique case (state_r)
      S_IDLE: if (query) begin
        n_nxt = ncap;
        i_nxt = '0;
        state_nxt = S_VRD;
      end
      S_VRD: state_nxt = (i_r >= n_r) ? S_SRD : S_VCHK;
      S_VCHK: begin
        cmd.op = CMD_VTX;
        state_nxt = S_VRES;
      end
      S_VRES: begin
        if (stat.hit) state_nxt = S_IDLE;
        else if ((i_r + 1'b1) >= n_r) begin
          // Last vertex missed: the segment scan starts at end vertex one.
          i_nxt = (AW+1)'(1);
          state_nxt = S_SRD;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_VRD;
          raddr = AW'(i_r + 1'b1);
        end
      end
      S_SRD: begin
        if (i_r == '0) i_nxt = (AW+1)'(1);
        state_nxt = (i_r >= n_r || n_r < (AW+1)'(2)) ? S_IDLE : S_SA;
      end
      S_SA: begin
        cmd.op = CMD_SEGA;
        raddr = AW'(i_r - 1'b1);
        state_nxt = S_SB;
      end
      S_SB: begin
        cmd.op = CMD_SEGB;
        state_nxt = S_SC;
      end
      S_SC: begin
        cmd.op = CMD_SEGC;
        state_nxt = S_SD;
      end
      S_SD: begin
        cmd.op = CMD_SEGD;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = CMD_DIV;
        if (stat.div_done) begin
          cmd.op = CMD_SEGE;
          state_nxt = S_SF;
        end
      end
      S_SF: begin
        cmd.op = CMD_SEGF;
        state_nxt = S_SE;
      end
      S_SE: begin
        cmd.op = CMD_SEGG;
        state_nxt = S_SRES;
      end
      S_SRES: begin
        if (stat.hit) state_nxt = S_IDLE;
        else begin
          i_nxt = i_r + 1'b1;
          raddr = AW'(i_r + 1'b1);
          state_nxt = S_SRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state; register the result strobe from the finishing state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      n_r     <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      n_r     <= n_nxt;
      done_r  <= 1'b0;
      if (state_r == S_VRES && stat.hit) begin
        done_r  <= 1'b1;
        kind_r  <= KIND_VERTEX;
        index_r <= INDEX_W'(i_r);
      end else if (state_r == S_SRES && stat.hit) begin
        done_r  <= 1'b1;
        kind_r  <= KIND_SEGMENT;
        index_r <= INDEX_W'(i_r);
      end else if (state_r == S_SRD && state_nxt == S_IDLE) begin
        done_r  <= 1'b1;
        kind_r  <= KIND_NONE;
        index_r <= '0;
      end
    end
  end

  assign busy  = (state_r != S_IDLE);
  assign done  = done_r;
  assign kind  = kind_r;
  assign index = index_r;

  // A result only follows a finishing state.
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(state_r) == S_VRES || $past(state_r) == S_SRES
                || $past(state_r) == S_SRD))
    else $error("result strobe without finishing state");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cmd.op == CMD_IDLE))
    else $error("datapath command while idle");
  a_seg_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SA) |-> (i_r != '0))
    else $error("segment scan at index zero");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for polyline_pick_hit_test_core: loads, hit-test queries and
// register writes, checked against an in-bench prediction of the pick result.
// Depends on pph_pkg and polyline_pick_hit_test_core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pph_pkg::*;

  localparam int NV        = 64;
  localparam int MAX_CYC   = 4000000;
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] index;
  } hit_t;

  // Tracks the polyline and radius, predicts each query's hit and checks results.
  class pick_tracker;
    logic signed [COORD_W-1:0] vx[NV];
    logic signed [COORD_W-1:0] vy[NV];
    int unsigned radius;
    int unsigned count;
    hit_t pending_hits[$];
    int errors, loads, queries, vtx_hits, seg_hits;

    function new();
      radius = 5;
      count = 0;
      foreach (vx[i]) begin
        vx[i] = '0;
        vy[i] = '0;
      end
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] data);
      if (idx == CFG_RADIUS) radius = 32'(data[RADIUS_W-1:0]);
      else count = 32'(data[COUNT_W-1:0]);
    endfunction

    // Squared distance from p to segment v..w in Q.32, with a clamped Q1.16 t.
    function longint seg_dist2(longint px, longint py, longint ax0, longint ay0,
                               longint bx, longint by);
      longint ex, ey, l2, ax, ay, d, t, dx, dy;
      ex = bx - ax0;
      ey = by - ay0;
      l2 = ex * ex + ey * ey;
      ax = px - ax0;
      ay = py - ay0;
      if (l2 == 0) return (ax * ax + ay * ay) <<< 32;
      d = ax * ex + ay * ey;
      if (d <= 0) t = 0;
      else if (d >= l2) t = 65536;
      else t = (d * 65536) / l2;
      dx = px * 65536 - (ax0 * 65536 + t * ex);
      dy = py * 65536 - (ay0 * 65536 + t * ey);
      return dx * dx + dy * dy;
    endfunction

    function hit_t predict_pick(longint px, longint py);
      hit_t h;
      int unsigned n;
      longint r2, dx, dy;
      n = (count > NV) ? NV : count;
      r2 = longint'(radius) * longint'(radius);
      for (int i = 0; i < n; i++) begin
        dx = longint'(vx[i]) - px;
        dy = longint'(vy[i]) - py;
        if (dx * dx + dy * dy <= r2) begin
          h.kind = KIND_VERTEX;
          h.index = INDEX_W'(i);
          return h;
        end
      end
      for (int i = 1; i < n; i++) begin
        if (seg_dist2(px, py, vx[i], vy[i], vx[i-1], vy[i-1]) <= (r2 <<< 32)) begin
          h.kind = KIND_SEGMENT;
          h.index = INDEX_W'(i);
          return h;
        end
      end
      h.kind = KIND_NONE;
      h.index = '0;
      return h;
    endfunction

    // Called for every accepted input transfer.
    function void note_item(logic op, logic [INDEX_W-1:0] idx,
                            logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
      if (op == OP_LOAD) begin
        vx[idx] = x;
        vy[idx] = y;
        loads++;
      end else begin
        pending_hits.insert(pending_hits.size(), predict_pick(x, y));
        queries++;
      end
    endfunction

    // Called for every result transfer.
    function void check(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] index);
      hit_t e;
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result kind=%0d index=%0d", $time, kind, index);
        errors++;
        return;
      end
      e = pending_hits.pop_front();
      if (e.kind == KIND_VERTEX) vtx_hits++;
      if (e.kind == KIND_SEGMENT) seg_hits++;
      if (kind !== e.kind) begin
        $display("%0t: hit_kind mismatch expected %0d actual %0d", $time, e.kind, kind);
        errors++;
      end
      if (index !== e.index) begin
        $display("%0t: hit_index mismatch expected %0d actual %0d", $time, e.index, index);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_opcode = 1'b0;
  logic [INDEX_W-1:0] in_vertex_index = '0;
  logic signed [COORD_W-1:0] in_coord_x = '0;
  logic signed [COORD_W-1:0] in_coord_y = '0;
  logic out_valid;
  logic [KIND_W-1:0] out_hit_kind;
  logic [INDEX_W-1:0] out_hit_index;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  pick_tracker tracker = new();
  int idle_pct = 0;
  int cycles = 0;

  polyline_pick_hit_test_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result monitor and run-time guard.
  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_valid) tracker.check(out_hit_kind, out_hit_index);
    if (cycles > MAX_CYC) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic signed [COORD_W-1:0] clip(int v);
    if (v > 4095) return COORD_W'(4095);
    if (v < -4096) return COORD_W'(-4096);
    return COORD_W'(v);
  endfunction

  // Presents one item and holds it until the transfer, then maybe idles.
  task automatic send(logic op, logic [INDEX_W-1:0] idx, int x, int y);
    start <= 1'b1;
    in_opcode <= op;
    in_vertex_index <= idx;
    in_coord_x <= clip(x);
    in_coord_y <= clip(y);
    do @(posedge clk); while (busy);
    tracker.note_item(op, idx, clip(x), clip(y));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  // Register write, issued only once the core has drained.
  task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending_hits.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Query near a vertex or a segment of the polyline in use, or anywhere.
  task automatic random_query();
    int n, j, r, x, y, jp;
    n = (tracker.count > NV) ? NV : tracker.count;
    r = tracker.radius + 4;
    j = (n > 0) ? $urandom_range(n - 1) : $urandom_range(NV - 1);
    case ($urandom_range(9))
      0, 1: begin
        x = int'($urandom_range(8191)) - 4096;
        y = int'($urandom_range(8191)) - 4096;
      end
      2, 3, 4: begin
        x = int'(tracker.vx[j]) + int'($urandom_range(2 * r)) - r;
        y = int'(tracker.vy[j]) + int'($urandom_range(2 * r)) - r;
      end
      default: begin
        if (j == 0) j = (n > 1) ? 1 : 0;
        jp = (j > 0) ? j - 1 : 0;
        x = (int'(tracker.vx[j]) + int'(tracker.vx[jp])) / 2
            + int'($urandom_range(2 * r)) - r;
        y = (int'(tracker.vy[j]) + int'(tracker.vy[jp])) / 2
            + int'($urandom_range(2 * r)) - r;
      end
    endcase
    send(OP_QUERY, INDEX_W'($urandom), x, y);
  endtask

  initial begin
    int cx, cy, n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every slot so that no query reads an unwritten entry.
    for (int i = 0; i < NV; i++)
      send(OP_LOAD, INDEX_W'(i), int'($urandom_range(8191)) - 4096,
           int'($urandom_range(8191)) - 4096);

    // Directed: count of zero answers nothing, default radius of five.
    send(OP_QUERY, 0, 0, 0);
    send(OP_LOAD, 0, 0, 0);
    send(OP_LOAD, 1, 100, 0);
    send(OP_LOAD, 2, 100, 0);
    send(OP_LOAD, 3, -4096, -4096);
    send(OP_LOAD, 63, 4095, 4095);
    write_reg(CFG_COUNT, 1);
    send(OP_QUERY, 0, 3, 4);
    send(OP_QUERY, 0, 50, 3);
    write_reg(CFG_COUNT, 4);
    send(OP_QUERY, 0, 50, 3);
    send(OP_QUERY, 0, 50, -6);
    send(OP_QUERY, 0, -3, 2);
    send(OP_QUERY, 0, 104, 3);
    send(OP_QUERY, 0, -2000, -2000);
    write_reg(CFG_RADIUS, 0);
    send(OP_QUERY, 0, 100, 0);
    send(OP_QUERY, 0, 50, 0);
    send(OP_QUERY, 0, 50, 1);
    write_reg(CFG_RADIUS, 255);
    write_reg(CFG_COUNT, 127);
    send(OP_QUERY, 0, 4095, -4096);
    send(OP_QUERY, 0, 4095, 4095);
    send(OP_QUERY, 0, -4096, 4095);

    // Random phases: no idling, heavy idling, none again, light idling.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 55 : (ph == 3) ? 14 : 0;
      for (int s = 0; s < 4; s++) begin
        case ($urandom_range(5))
          0: write_reg(CFG_RADIUS, 0);
          1: write_reg(CFG_RADIUS, 255);
          default: write_reg(CFG_RADIUS, CFG_W'($urandom_range(30)));
        endcase
        case ($urandom_range(9))
          0: n = 64;
          1: n = $urandom_range(127, 65);
          2: n = $urandom_range(1);
          default: n = $urandom_range(12, 2);
        endcase
        // A fresh chain of nearby vertices for the small polylines.
        if (n <= 12) begin
          cx = int'($urandom_range(8000)) - 4000;
          cy = int'($urandom_range(8000)) - 4000;
          for (int i = 0; i < n; i++) begin
            send(OP_LOAD, INDEX_W'(i), cx, cy);
            if ($urandom_range(5) != 0) begin
              cx = clip(cx + int'($urandom_range(80)) - 40);
              cy = clip(cy + int'($urandom_range(80)) - 40);
            end
          end
        end
        write_reg(CFG_COUNT, CFG_W'(n));
        for (int k = 0; k < 16; k++) begin
          if ($urandom_range(9) == 0)
            send(OP_LOAD, INDEX_W'($urandom), int'($urandom_range(8191)) - 4096,
                 int'($urandom_range(8191)) - 4096);
          else
            random_query();
        end
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending_hits.size() != 0 || busy) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d loads and %0d queries (%0d vertex hits, %0d segment hits).",
             tracker.loads, tracker.queries, tracker.vtx_hits, tracker.seg_hits);
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
